[rtl/core/sscu_pkg.sv]
// ----------------------------------------------------------------------------
// sscu_pkg
// Shared types and constants of the slot cache update block.
// ----------------------------------------------------------------------------
package sscu_pkg;

  localparam int NUM_SLOTS_DEF = 2048;
  localparam int MAP_CAP_DEF   = 4096;
  localparam int HASH_SIZE_DEF = 4096;

  localparam int ENTRY_W = 16;
  localparam int TOKEN_W = 32;

  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam logic [31:0] NO_TOKEN = 32'hFFFF_FFFF;

  localparam logic [30:0] PREFILL_RST = 31'd0;
  localparam logic [11:0] SLOTS_RST   = 12'd2048;
  localparam logic [15:0] BASE_RST    = 16'd2048;

  typedef enum logic [1:0] {
    CFG_PREFILL = 2'd0,
    CFG_SLOTS   = 2'd1,
    CFG_BASE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PM_FIND = 2'd0,
    PM_DEL  = 2'd1,
    PM_INS  = 2'd2
  } pmode_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASS,
    ST_DMAP_RD,
    ST_DMAP_CHK,
    ST_HASH,
    ST_PRB_HOME,
    ST_PRB_RD,
    ST_PRB_E,
    ST_PRB_T,
    ST_HIT,
    ST_SWP_INIT,
    ST_SWP_RD,
    ST_SWP_CHK,
    ST_OLD_RD,
    ST_OLD_CHK,
    ST_DIR_CLR,
    ST_DIR_SET,
    ST_SHF_RD,
    ST_SHF_E,
    ST_SHF_T,
    ST_SHF_H,
    ST_SHF_END,
    ST_FILL,
    ST_FIN
  } state_t;

endpackage

[rtl/core/sscu_ram.sv]
// ----------------------------------------------------------------------------
// sscu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sscu_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rq
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq <= mem[ra];
  end

endmodule

[rtl/core/sscu_hash.sv]
// ----------------------------------------------------------------------------
// sscu_hash
// Multiplicative hash: home bucket of a token, taken from the registered product.
// ----------------------------------------------------------------------------
module sscu_hash #(
  parameter int HASH_SIZE = sscu_pkg::HASH_SIZE_DEF,
  parameter int AW        = 12
) (
  input  logic          clk,
  input  logic [31:0]   t_in,
  output logic [AW-1:0] home
);

  localparam logic [15:0] HMASK = 16'(HASH_SIZE - 1);

  logic [31:0] prod_r;
  logic [15:0] hm;

  always_ff @(posedge clk) begin
    prod_r <= t_in * sscu_pkg::HASH_MUL;
  end

  assign hm   = prod_r[31:16] & HMASK;
  assign home = hm[AW-1:0];

endmodule

[rtl/core/sieve_slot_cache_update.sv]
// ----------------------------------------------------------------------------
// sieve_slot_cache_update
// Maps a token position to a cache slot with SIEVE eviction.
//
// The input channel carries a token position and the sequence length; the
// result channel returns the slot (-1 for an invalid query) and a miss flag.
// Both channels move one beat when valid is high and stall is low.
// The prefill length, slot count and decode base registers are written via
// the cfg port; the user must write them only while no beat is in flight,
// as the block does not enforce it. One item is worked at a time by a
// sequencer around three RAMs (token row, visited bits, slot map), each with
// a registered read port, and one pipelined hash multiplier. Invalid and
// decode beats go from classification straight to the result. A direct-map
// hit sets the visited bit; a miss sweeps the hand over visited slots,
// clearing them, clears the old token's map entry if it is mapped and writes
// the new one. In hash mode each map pass (find, delete, insert) probes from
// the home bucket; a delete closes its gap by backward shifts. After reset a
// clearing pass over max(MAP_CAP, HASH_SIZE, NUM_SLOTS) entries runs with
// in_stall high. The result sits in an output register; while out_stall
// holds, the finished item waits and no new beat is taken.
// ----------------------------------------------------------------------------
module sieve_slot_cache_update #(
  parameter int NUM_SLOTS = sscu_pkg::NUM_SLOTS_DEF,
  parameter int MAP_CAP   = sscu_pkg::MAP_CAP_DEF,
  parameter int HASH_SIZE = sscu_pkg::HASH_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_token_pos,
  input  logic        [30:0] in_seq_len,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_slot,
  output logic               out_miss,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [30:0] cfg_data
);

  localparam int MAP_DEPTH = (MAP_CAP > HASH_SIZE) ? MAP_CAP : HASH_SIZE;
  localparam int CLR_DEPTH = (MAP_DEPTH > NUM_SLOTS) ? MAP_DEPTH : NUM_SLOTS;
  localparam int MW  = $clog2(MAP_DEPTH);
  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int NW  = SW + 1;
  localparam int CW  = $clog2(HASH_SIZE + 1);
  localparam int CLW = $clog2(CLR_DEPTH);
  localparam int EW  = sscu_pkg::ENTRY_W;
  localparam int TW  = sscu_pkg::TOKEN_W;
  localparam logic [MW:0] HMASK_W = (MW + 1)'(HASH_SIZE - 1);

  sscu_pkg::state_t state_r, state_nxt;
  sscu_pkg::pmode_t pmode_r, pmode_nxt;

  logic [30:0]    prefill_r;
  logic [11:0]    slots_r;
  logic [15:0]    base_r;
  logic [31:0]    pos_r, pos_nxt;
  logic [30:0]    seq_r, seq_nxt;
  logic           direct_r, direct_nxt;
  logic [31:0]    tgt_r, tgt_nxt;
  logic [MW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  logic [SW-1:0]  h_r, h_nxt;
  logic [SW-1:0]  hand_r, hand_nxt;
  logic [31:0]    old_r, old_nxt;
  logic [MW-1:0]  i_r, i_nxt;
  logic [MW-1:0]  j_r, j_nxt;
  logic [31:0]    res_slot_r, res_slot_nxt;
  logic           res_miss_r, res_miss_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_slot_r, out_slot_nxt;
  logic           out_miss_r, out_miss_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;

  logic           map_we, tok_we, vis_we;
  logic [MW-1:0]  map_wa, map_ra;
  logic [EW-1:0]  map_wd, map_q;
  logic [SW-1:0]  tok_wa, tok_ra, vis_wa, vis_ra;
  logic [TW-1:0]  tok_wd, tok_q;
  logic           vis_wd, vis_q;
  logic [31:0]    hash_in;
  logic [MW-1:0]  home;

  logic [NW-1:0]  nslots;
  logic [NW-1:0]  hp1;
  logic [SW-1:0]  h_inc;
  logic [SW-1:0]  hand_start;
  logic [MW:0]    idx_p1, i_p1;
  logic [MW-1:0]  idx_inc, i_inc;
  logic [MW-1:0]  t_idx;
  logic           is_inv, is_dec, direct;
  logic [31:0]    dec_sum;
  logic [31:0]    dec_val;
  logic [EW-1:0]  em1, erm1;
  logic           e_zero, e_ok, er_ok;
  logic           prb_exhaust, tok_match, move, out_free;
  logic [EW-1:0]  h_entry;

  sscu_ram #(.DW(EW), .DEPTH(MAP_DEPTH), .AW(MW)) u_map (
    .clk(clk), .we(map_we), .wa(map_wa), .wd(map_wd), .ra(map_ra), .rq(map_q)
  );

  sscu_ram #(.DW(TW), .DEPTH(NUM_SLOTS), .AW(SW)) u_tok (
    .clk(clk), .we(tok_we), .wa(tok_wa), .wd(tok_wd), .ra(tok_ra), .rq(tok_q)
  );

  sscu_ram #(.DW(1), .DEPTH(NUM_SLOTS), .AW(SW)) u_vis (
    .clk(clk), .we(vis_we), .wa(vis_wa), .wd(vis_wd), .ra(vis_ra), .rq(vis_q)
  );

  sscu_hash #(.HASH_SIZE(HASH_SIZE), .AW(MW)) u_hash (
    .clk(clk), .t_in(hash_in), .home(home)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefill_r <= sscu_pkg::PREFILL_RST;
      slots_r   <= sscu_pkg::SLOTS_RST;
      base_r    <= sscu_pkg::BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sscu_pkg::CFG_PREFILL: prefill_r <= cfg_data;
        sscu_pkg::CFG_SLOTS:   slots_r   <= cfg_data[11:0];
        sscu_pkg::CFG_BASE:    base_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slots_r == 12'd0) begin
      nslots = NW'(1);
    end else if (17'(slots_r) > 17'(NUM_SLOTS)) begin
      nslots = NW'(NUM_SLOTS);
    end else begin
      nslots = NW'(slots_r);
    end
  end

  assign hp1        = NW'(h_r) + NW'(1);
  assign h_inc      = (hp1 == nslots) ? '0 : hp1[SW-1:0];
  assign hand_start = (NW'(hand_r) >= nslots) ? '0 : hand_r;
  assign idx_p1     = ((MW + 1)'(idx_r) + (MW + 1)'(1)) & HMASK_W;
  assign idx_inc    = idx_p1[MW-1:0];
  assign i_p1       = ((MW + 1)'(i_r) + (MW + 1)'(1)) & HMASK_W;
  assign i_inc      = i_p1[MW-1:0];
  assign t_idx      = pos_r[MW-1:0];

  assign is_inv  = pos_r[31] || (pos_r[30:0] >= seq_r);
  assign is_dec  = pos_r[30:0] >= prefill_r;
  assign direct  = prefill_r < 31'(MAP_CAP);
  assign dec_sum = {1'b0, pos_r[30:0] - prefill_r} + {16'd0, base_r};
  assign dec_val = dec_sum[31] ? 32'h7FFF_FFFF : dec_sum;

  assign em1         = map_q - EW'(1);
  assign erm1        = e_r - EW'(1);
  assign e_zero      = map_q == '0;
  assign e_ok        = !e_zero && (17'(map_q) <= 17'(NUM_SLOTS));
  assign er_ok       = (e_r != '0) && (17'(e_r) <= 17'(NUM_SLOTS));
  assign prb_exhaust = cnt_r == CW'(HASH_SIZE);
  assign tok_match   = tok_q == tgt_r;
  assign move        = (j_r < i_r) ? ((home <= j_r) || (home > i_r))
                                   : ((home <= j_r) && (home > i_r));
  assign out_free    = !out_valid_r || !out_stall;
  assign h_entry     = EW'(h_r) + EW'(1);

  assign hash_in = (state_r == sscu_pkg::ST_SHF_T)
                   ? (er_ok ? tok_q : sscu_pkg::NO_TOKEN) : tgt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sscu_pkg::ST_CLEAR:
        if (clr_r == CLW'(CLR_DEPTH - 1)) state_nxt = sscu_pkg::ST_IDLE;
      sscu_pkg::ST_IDLE:
        if (in_valid) state_nxt = sscu_pkg::ST_CLASS;
      sscu_pkg::ST_CLASS: begin
        if (is_inv || is_dec) state_nxt = sscu_pkg::ST_FIN;
        else if (direct)      state_nxt = sscu_pkg::ST_DMAP_RD;
        else                  state_nxt = sscu_pkg::ST_HASH;
      end
      sscu_pkg::ST_DMAP_RD:  state_nxt = sscu_pkg::ST_DMAP_CHK;
      sscu_pkg::ST_DMAP_CHK: state_nxt = e_ok ? sscu_pkg::ST_HIT : sscu_pkg::ST_SWP_INIT;
      sscu_pkg::ST_HASH:     state_nxt = sscu_pkg::ST_PRB_HOME;
      sscu_pkg::ST_PRB_HOME: state_nxt = sscu_pkg::ST_PRB_RD;
      sscu_pkg::ST_PRB_RD: begin
        if (prb_exhaust) begin
          case (pmode_r)
            sscu_pkg::PM_DEL: state_nxt = sscu_pkg::ST_HASH;
            sscu_pkg::PM_INS: state_nxt = sscu_pkg::ST_FILL;
            default:          state_nxt = sscu_pkg::ST_SWP_INIT;
          endcase
        end else begin
          state_nxt = sscu_pkg::ST_PRB_E;
        end
      end
      sscu_pkg::ST_PRB_E: begin
        if (e_zero) begin
          case (pmode_r)
            sscu_pkg::PM_DEL: state_nxt = sscu_pkg::ST_HASH;
            sscu_pkg::PM_INS: state_nxt = sscu_pkg::ST_FILL;
            default:          state_nxt = sscu_pkg::ST_SWP_INIT;
          endcase
        end else if (!e_ok) begin
          state_nxt = sscu_pkg::ST_PRB_RD;
        end else begin
          state_nxt = sscu_pkg::ST_PRB_T;
        end
      end
      sscu_pkg::ST_PRB_T: begin
        if (tok_match) begin
          case (pmode_r)
            sscu_pkg::PM_DEL: state_nxt = sscu_pkg::ST_SHF_RD;
            sscu_pkg::PM_INS: state_nxt = sscu_pkg::ST_FILL;
            default:          state_nxt = sscu_pkg::ST_HIT;
          endcase
        end else begin
          state_nxt = sscu_pkg::ST_PRB_RD;
        end
      end
      sscu_pkg::ST_HIT:      state_nxt = sscu_pkg::ST_FIN;
      sscu_pkg::ST_SWP_INIT: state_nxt = sscu_pkg::ST_SWP_RD;
      sscu_pkg::ST_SWP_RD:   state_nxt = sscu_pkg::ST_SWP_CHK;
      sscu_pkg::ST_SWP_CHK:  state_nxt = vis_q ? sscu_pkg::ST_SWP_RD : sscu_pkg::ST_OLD_RD;
      sscu_pkg::ST_OLD_RD:   state_nxt = sscu_pkg::ST_OLD_CHK;
      sscu_pkg::ST_OLD_CHK: begin
        if (!direct_r)                 state_nxt = sscu_pkg::ST_HASH;
        else if (tok_q < 32'(MAP_CAP)) state_nxt = sscu_pkg::ST_DIR_CLR;
        else                           state_nxt = sscu_pkg::ST_DIR_SET;
      end
      sscu_pkg::ST_DIR_CLR: state_nxt = sscu_pkg::ST_DIR_SET;
      sscu_pkg::ST_DIR_SET: state_nxt = sscu_pkg::ST_FILL;
      sscu_pkg::ST_SHF_RD:
        state_nxt = prb_exhaust ? sscu_pkg::ST_SHF_END : sscu_pkg::ST_SHF_E;
      sscu_pkg::ST_SHF_E:
        state_nxt = e_zero ? sscu_pkg::ST_SHF_END : sscu_pkg::ST_SHF_T;
      sscu_pkg::ST_SHF_T:   state_nxt = sscu_pkg::ST_SHF_H;
      sscu_pkg::ST_SHF_H:   state_nxt = sscu_pkg::ST_SHF_RD;
      sscu_pkg::ST_SHF_END: state_nxt = sscu_pkg::ST_HASH;
      sscu_pkg::ST_FILL:    state_nxt = sscu_pkg::ST_FIN;
      sscu_pkg::ST_FIN:
        if (out_free) state_nxt = sscu_pkg::ST_IDLE;
      default: state_nxt = sscu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt      = pos_r;
    seq_nxt      = seq_r;
    direct_nxt   = direct_r;
    tgt_nxt      = tgt_r;
    pmode_nxt    = pmode_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    e_nxt        = e_r;
    h_nxt        = h_r;
    hand_nxt     = hand_r;
    old_nxt      = old_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    res_slot_nxt = res_slot_r;
    res_miss_nxt = res_miss_r;
    out_slot_nxt = out_slot_r;
    out_miss_nxt = out_miss_r;
    clr_nxt      = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    map_we = 1'b0;
    map_wa = idx_r;
    map_wd = '0;
    map_ra = idx_r;
    tok_we = 1'b0;
    tok_wa = h_r;
    tok_wd = pos_r;
    tok_ra = em1[SW-1:0];
    vis_we = 1'b0;
    vis_wa = h_r;
    vis_wd = 1'b1;
    vis_ra = h_r;
    case (state_r)
      sscu_pkg::ST_CLEAR: begin
        map_we  = (CLW + 1)'(clr_r) < (CLW + 1)'(MAP_DEPTH);
        map_wa  = clr_r[MW-1:0];
        tok_we  = (CLW + 1)'(clr_r) < (CLW + 1)'(NUM_SLOTS);
        tok_wa  = clr_r[SW-1:0];
        tok_wd  = sscu_pkg::NO_TOKEN;
        vis_we  = tok_we;
        vis_wa  = clr_r[SW-1:0];
        vis_wd  = 1'b0;
        clr_nxt = clr_r + CLW'(1);
      end
      sscu_pkg::ST_IDLE: begin
        pos_nxt = in_token_pos;
        seq_nxt = in_seq_len;
      end
      sscu_pkg::ST_CLASS: begin
        direct_nxt   = direct;
        tgt_nxt      = pos_r;
        pmode_nxt    = sscu_pkg::PM_FIND;
        res_miss_nxt = 1'b0;
        res_slot_nxt = is_inv ? 32'hFFFF_FFFF : dec_val;
      end
      sscu_pkg::ST_DMAP_RD: map_ra = t_idx;
      sscu_pkg::ST_DMAP_CHK: h_nxt = em1[SW-1:0];
      sscu_pkg::ST_PRB_HOME: begin
        idx_nxt = home;
        cnt_nxt = '0;
      end
      sscu_pkg::ST_PRB_RD: begin
        if (prb_exhaust && pmode_r == sscu_pkg::PM_DEL) begin
          tgt_nxt   = pos_r;
          pmode_nxt = sscu_pkg::PM_INS;
        end
      end
      sscu_pkg::ST_PRB_E: begin
        e_nxt = map_q;
        if (e_zero) begin
          if (pmode_r == sscu_pkg::PM_DEL) begin
            tgt_nxt   = pos_r;
            pmode_nxt = sscu_pkg::PM_INS;
          end else if (pmode_r == sscu_pkg::PM_INS) begin
            map_we = 1'b1;
            map_wd = h_entry;
          end
        end else if (!e_ok) begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      sscu_pkg::ST_PRB_T: begin
        if (tok_match) begin
          h_nxt = (pmode_r == sscu_pkg::PM_FIND) ? erm1[SW-1:0] : h_r;
          i_nxt = idx_r;
          j_nxt = idx_r;
          cnt_nxt = CW'(1);
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      sscu_pkg::ST_HIT: begin
        vis_we       = 1'b1;
        res_slot_nxt = 32'(h_r);
        res_miss_nxt = 1'b0;
      end
      sscu_pkg::ST_SWP_INIT: h_nxt = hand_start;
      sscu_pkg::ST_SWP_CHK: begin
        if (vis_q) begin
          vis_we = 1'b1;
          vis_wd = 1'b0;
          h_nxt  = h_inc;
        end
      end
      sscu_pkg::ST_OLD_RD: tok_ra = h_r;
      sscu_pkg::ST_OLD_CHK: begin
        old_nxt = tok_q;
        if (!tok_q[31]) begin
          tgt_nxt   = tok_q;
          pmode_nxt = sscu_pkg::PM_DEL;
        end else begin
          tgt_nxt   = pos_r;
          pmode_nxt = sscu_pkg::PM_INS;
        end
      end
      sscu_pkg::ST_DIR_CLR: begin
        map_we = 1'b1;
        map_wa = old_r[MW-1:0];
      end
      sscu_pkg::ST_DIR_SET: begin
        map_we = 1'b1;
        map_wa = t_idx;
        map_wd = h_entry;
      end
      sscu_pkg::ST_SHF_RD: begin
        map_ra = i_inc;
        if (!prb_exhaust) begin
          i_nxt   = i_inc;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      sscu_pkg::ST_SHF_E: e_nxt = map_q;
      sscu_pkg::ST_SHF_H: begin
        if (move) begin
          map_we = 1'b1;
          map_wa = j_r;
          map_wd = e_r;
          j_nxt  = i_r;
        end
      end
      sscu_pkg::ST_SHF_END: begin
        map_we    = 1'b1;
        map_wa    = j_r;
        tgt_nxt   = pos_r;
        pmode_nxt = sscu_pkg::PM_INS;
      end
      sscu_pkg::ST_FILL: begin
        tok_we       = 1'b1;
        vis_we       = 1'b1;
        hand_nxt     = h_inc;
        res_slot_nxt = 32'(h_r);
        res_miss_nxt = 1'b1;
      end
      sscu_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = res_slot_r;
          out_miss_nxt  = res_miss_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sscu_pkg::ST_CLEAR;
      pmode_r     <= sscu_pkg::PM_FIND;
      hand_r      <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pmode_r     <= pmode_nxt;
      hand_r      <= hand_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    seq_r      <= seq_nxt;
    direct_r   <= direct_nxt;
    tgt_r      <= tgt_nxt;
    idx_r      <= idx_nxt;
    e_r        <= e_nxt;
    h_r        <= h_nxt;
    old_r      <= old_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    res_slot_r <= res_slot_nxt;
    res_miss_r <= res_miss_nxt;
    out_slot_r <= out_slot_nxt;
    out_miss_r <= out_miss_nxt;
  end

  assign in_stall  = state_r != sscu_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_miss  = out_miss_r;

`ifndef ASSERT_OFF
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sscu_pkg::ST_CLEAR |-> !out_valid_r)
    else $error("result valid during clearing pass");
  a_miss_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_miss_r |-> out_slot_r < 32'(NUM_SLOTS))
    else $error("evicted slot out of range");
  a_invalid_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_slot_r[31] |-> !out_miss_r)
    else $error("invalid query flagged as miss");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HASH_SIZE))
    else $error("probe count past table size");
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sscu_pkg::ST_FIN && !out_free |=> state_r == sscu_pkg::ST_FIN)
    else $error("result left while output busy");
`endif

endmodule
